[design/dti_pkg.sv]
// dti_pkg: shared types, constants and helpers of the time interleaver
// used by every module of the block; depends on nothing else

package dti_pkg;

    // field widths fixed by the interface
    localparam int SAMPLE_W   = 8;
    localparam int LEN_W      = 13;
    localparam int TABLE_W    = 64;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 64;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_VEC_LEN        = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCRAMBLE_TABLE = 4'd1;

    // register reset values
    localparam logic [LEN_W-1:0]   LEN_RESET   = 13'd4096;
    localparam logic [TABLE_W-1:0] TABLE_RESET = 64'hF7B3D591E6A2C480;

    // default geometry
    localparam int DTI_BRANCHES   = 16;
    localparam int DTI_MAX_VECTOR = 4096;

    // command fields sized for the largest legal geometry
    localparam int SLOT_MAX_W  = 4;
    localparam int POS_MAX_W   = 16;
    localparam int QUEUE_DEPTH = 4;

    // one accepted element, as handed from front to back
    typedef struct packed {
        logic [SAMPLE_W-1:0]   data;
        logic [SLOT_MAX_W-1:0] slot;
        logic [POS_MAX_W-1:0]  pos;
        logic                  group_done;
    } cmd_t;

    // back end sequencer states
    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_READ
    } back_state_t;

    // reduce a 4-bit table entry below the branch count
    function automatic logic [3:0] entry_mod(input logic [3:0] e, input int branches);
        logic [4:0] r;
        logic [4:0] b;
        r = {1'b0, e};
        b = 5'(branches);
        for (int i = 0; i < 8; i++) begin
            if (r >= b) begin
                r = r - b;
            end
        end
        return r[3:0];
    endfunction

endpackage

[design/dti_queue.sv]
// dti_queue: short command queue between front and back
// depends on dti_pkg for cmd_t and the queue depth

module dti_queue
    import dti_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic push_ready,
    input  logic pop,
    output cmd_t pop_cmd,
    output logic pop_valid
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t               entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               do_push;
    logic               do_pop;

    // status
    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

[design/dti_front.sv]
// dti_front: accepts elements, tracks slot, position and group, tags group ends
// depends on dti_pkg; holds the effective vector length in groups

module dti_front
    import dti_pkg::*;
#(
    parameter int BRANCHES   = DTI_BRANCHES,
    parameter int MAX_VECTOR = DTI_MAX_VECTOR
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    input  logic [SAMPLE_W-1:0] sample_in,
    output logic               item_stall,
    input  logic               len_wr,
    input  logic [LEN_W-1:0]   len_data,
    output logic               len_busy,
    input  logic               clear_busy,
    input  logic               q_ready,
    output logic               q_push,
    output cmd_t               q_cmd
);

    localparam int SLOT_W = $clog2(BRANCHES);
    localparam int POS_W  = $clog2(MAX_VECTOR);
    localparam int QMAX   = MAX_VECTOR / BRANCHES;
    localparam int GRP_W  = $clog2(QMAX + 1);
    localparam int FRAC   = LEN_W + 4;
    localparam int PROD_W = LEN_W + FRAC;
    localparam int RECIP  = (1 << FRAC) / BRANCHES;
    localparam int CMP_W  = LEN_W + GRP_W;
    localparam int LR_Q   = int'(LEN_RESET) / BRANCHES;
    localparam int Q_RST  = (LR_Q < 1) ? 1 : ((LR_Q > QMAX) ? QMAX : LR_Q);
    localparam logic [SLOT_W-1:0] LAST_K = SLOT_W'(BRANCHES - 1);

    logic [SLOT_W-1:0] slot_reg;
    logic [SLOT_W-1:0] slot_next;
    logic [POS_W-1:0]  pos_reg;
    logic [POS_W-1:0]  pos_next;
    logic [SLOT_W-1:0] cnt_reg;
    logic [SLOT_W-1:0] cnt_next;
    logic [GRP_W-1:0]  grp_reg;
    logic [GRP_W-1:0]  grp_next;
    logic [GRP_W-1:0]  limit_reg;
    logic [GRP_W-1:0]  limit_next;
    logic [LEN_W-1:0]  len_reg;
    logic [LEN_W-1:0]  quot_reg;
    logic              st1_reg;
    logic              st2_reg;
    logic [PROD_W-1:0] prod;
    logic [LEN_W-1:0]  quot_times_b;
    logic [LEN_W-1:0]  remainder;
    logic [LEN_W-1:0]  quot_fixed;
    logic [CMP_W-1:0]  quot_wide;
    logic              accept;
    logic              group_done;
    logic [GRP_W-1:0]  grp_inc;
    logic              vector_end;

    // handshake
    assign len_busy   = st1_reg || st2_reg;
    assign item_stall = !q_ready || len_busy || clear_busy;
    assign accept     = item_valid && !item_stall;
    assign q_push     = accept;

    // length in groups: reciprocal estimate, then one correction and clamping
    assign prod         = PROD_W'(len_reg) * PROD_W'(RECIP);
    assign quot_times_b = LEN_W'((LEN_W + 5)'(quot_reg) * (LEN_W + 5)'(BRANCHES));
    assign remainder    = len_reg - quot_times_b;

    always_comb
    begin
        quot_fixed = quot_reg;
        if (remainder >= LEN_W'(BRANCHES))
        begin
            quot_fixed = quot_reg + 1'b1;
        end
        quot_wide  = CMP_W'(quot_fixed);
        limit_next = limit_reg;
        if (st2_reg)
        begin
            if (quot_wide == '0)
            begin
                limit_next = GRP_W'(1);
            end
            else if (quot_wide > CMP_W'(QMAX))
            begin
                limit_next = GRP_W'(QMAX);
            end
            else
            begin
                limit_next = GRP_W'(quot_wide);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st1_reg   <= 1'b0;
            st2_reg   <= 1'b0;
            limit_reg <= GRP_W'(Q_RST);
        end
        else
        begin
            st1_reg   <= len_wr;
            st2_reg   <= st1_reg;
            limit_reg <= limit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (len_wr)
        begin
            len_reg <= len_data;
        end
        if (st1_reg)
        begin
            quot_reg <= prod[PROD_W-1:FRAC];
        end
    end

    // position tracking
    assign group_done = (cnt_reg == LAST_K);
    assign grp_inc    = grp_reg + GRP_W'(group_done);
    assign vector_end = (grp_inc >= limit_reg);

    always_comb
    begin
        slot_next = slot_reg;
        pos_next  = pos_reg;
        cnt_next  = cnt_reg;
        grp_next  = grp_reg;
        if (accept)
        begin
            if (vector_end)
            begin
                slot_next = (slot_reg == LAST_K) ? '0 : slot_reg + 1'b1;
                pos_next  = '0;
                cnt_next  = '0;
                grp_next  = '0;
            end
            else
            begin
                pos_next = pos_reg + 1'b1;
                cnt_next = group_done ? '0 : cnt_reg + 1'b1;
                grp_next = grp_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= '0;
            pos_reg  <= '0;
            cnt_reg  <= '0;
            grp_reg  <= '0;
        end
        else
        begin
            slot_reg <= slot_next;
            pos_reg  <= pos_next;
            cnt_reg  <= cnt_next;
            grp_reg  <= grp_next;
        end
    end

    // command to the back end
    always_comb
    begin
        q_cmd.data       = sample_in;
        q_cmd.slot       = SLOT_MAX_W'(slot_reg);
        q_cmd.pos        = POS_MAX_W'(pos_reg);
        q_cmd.group_done = group_done;
    end

endmodule

[design/dti_back.sv]
// dti_back: vector store, clearing sweep, group read sequencer and output buffer
// depends on dti_pkg for cmd_t, back_state_t and entry_mod

module dti_back
    import dti_pkg::*;
#(
    parameter int BRANCHES   = DTI_BRANCHES,
    parameter int MAX_VECTOR = DTI_MAX_VECTOR
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  cmd_t                q_cmd,
    output logic                q_pop,
    input  logic [TABLE_W-1:0]  scramble_table,
    output logic                result_valid,
    input  logic                result_stall,
    output logic [SAMPLE_W-1:0] sample_out,
    output logic                group_last,
    output logic                clear_busy
);

    localparam int SLOT_W    = $clog2(BRANCHES);
    localparam int POS_W     = $clog2(MAX_VECTOR);
    localparam int MEM_DEPTH = BRANCHES * MAX_VECTOR;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    localparam logic [SLOT_W-1:0] LAST_K    = SLOT_W'(BRANCHES - 1);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MEM_DEPTH - 1);
    localparam logic [ADDR_W-1:0] ROW_SIZE  = ADDR_W'(MAX_VECTOR);

    back_state_t         state_reg;
    back_state_t         state_next;
    logic [ADDR_W-1:0]   clr_addr_reg;
    logic [ADDR_W-1:0]   clr_addr_next;
    logic [SLOT_W-1:0]   k_reg;
    logic [SLOT_W-1:0]   k_next;
    logic [SLOT_W-1:0]   src_reg;
    logic [SLOT_W-1:0]   src_next;
    logic [POS_W-1:0]    base_reg;
    logic [POS_W-1:0]    base_next;

    logic [SAMPLE_W-1:0] mem [MEM_DEPTH];
    logic [SAMPLE_W-1:0] rd_data_reg;
    logic                rd_vld_reg;
    logic                rd_last_reg;

    logic [SAMPLE_W-1:0] ob_data_reg [2];
    logic                ob_last_reg [2];
    logic                ob_wp_reg;
    logic                ob_rp_reg;
    logic [1:0]          ob_cnt_reg;
    logic [1:0]          ob_cnt_next;

    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    logic [SAMPLE_W-1:0] mem_wdata;
    logic                rd_en;
    logic [ADDR_W-1:0]   rd_addr;
    logic [3:0]          entry_arr [BRANCHES];
    logic [3:0]          offset;
    logic [POS_W-1:0]    idx;
    logic [SLOT_W-1:0]   cmd_slot;
    logic [POS_W-1:0]    cmd_pos;
    logic                out_pop;
    logic [2:0]          occupancy;
    logic                can_issue;

    // command fields at this geometry
    assign cmd_slot = q_cmd.slot[SLOT_W-1:0];
    assign cmd_pos  = q_cmd.pos[POS_W-1:0];

    // scramble offset and read address of result k
    always_comb
    begin
        for (int i = 0; i < BRANCHES; i++)
        begin
            entry_arr[i] = scramble_table[4*i +: 4];
        end
    end

    assign offset  = entry_mod(entry_arr[k_reg], BRANCHES);
    assign idx     = base_reg + POS_W'(offset);
    assign rd_addr = ADDR_W'(src_reg) * ROW_SIZE + ADDR_W'(idx);

    // read credit against the two-entry output buffer
    assign out_pop   = result_valid && !result_stall;
    assign occupancy = 3'(ob_cnt_reg) + 3'(rd_vld_reg) - 3'(out_pop);
    assign can_issue = (occupancy < 3'd2);

    // next state
    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        k_next        = k_reg;
        src_next      = src_reg;
        base_next     = base_reg;
        case (state_reg)
            BK_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == LAST_ADDR)
                begin
                    state_next = BK_IDLE;
                end
            end
            BK_IDLE:
            begin
                if (q_valid && q_cmd.group_done)
                begin
                    state_next = BK_READ;
                    k_next     = '0;
                    src_next   = cmd_slot;
                    base_next  = cmd_pos - POS_W'(BRANCHES - 1);
                end
            end
            BK_READ:
            begin
                if (can_issue)
                begin
                    k_next   = k_reg + 1'b1;
                    src_next = (src_reg == '0) ? LAST_K : src_reg - 1'b1;
                    if (k_reg == LAST_K)
                    begin
                        state_next = BK_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        q_pop     = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = clr_addr_reg;
        mem_wdata = '0;
        rd_en     = 1'b0;
        case (state_reg)
            BK_CLEAR:
            begin
                mem_we = 1'b1;
            end
            BK_IDLE:
            begin
                q_pop     = q_valid;
                mem_we    = q_valid;
                mem_waddr = ADDR_W'(cmd_slot) * ROW_SIZE + ADDR_W'(cmd_pos);
                mem_wdata = q_cmd.data;
            end
            BK_READ:
            begin
                rd_en = can_issue;
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    assign clear_busy = (state_reg == BK_CLEAR);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= BK_CLEAR;
            clr_addr_reg <= '0;
            k_reg        <= '0;
            rd_vld_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            k_reg        <= k_next;
            rd_vld_reg   <= rd_en;
        end
    end

    always_ff @(posedge clk)
    begin
        src_reg     <= src_next;
        base_reg    <= base_next;
        rd_last_reg <= (k_reg == LAST_K);
    end

    // vector store
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // output buffer
    always_comb
    begin
        ob_cnt_next = ob_cnt_reg;
        if (rd_vld_reg && !out_pop)
        begin
            ob_cnt_next = ob_cnt_reg + 1'b1;
        end
        else if (!rd_vld_reg && out_pop)
        begin
            ob_cnt_next = ob_cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ob_wp_reg  <= 1'b0;
            ob_rp_reg  <= 1'b0;
            ob_cnt_reg <= '0;
        end
        else
        begin
            ob_cnt_reg <= ob_cnt_next;
            if (rd_vld_reg)
            begin
                ob_wp_reg <= !ob_wp_reg;
            end
            if (out_pop)
            begin
                ob_rp_reg <= !ob_rp_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_vld_reg)
        begin
            ob_data_reg[ob_wp_reg] <= rd_data_reg;
            ob_last_reg[ob_wp_reg] <= rd_last_reg;
        end
    end

    assign result_valid = (ob_cnt_reg != '0);
    assign sample_out   = ob_data_reg[ob_rp_reg];
    assign group_last   = ob_last_reg[ob_rp_reg];

endmodule

[design/dab_time_interleaver_top.sv]
// Convolutional time interleaver with 16 branches over vectors of 8-bit elements.
// After reset the vector store (BRANCHES * MAX_VECTOR entries, 65536 by default) is
// cleared one entry per cycle; items are stalled during the sweep, configuration writes
// are taken. Each item costs one store write; the 16th item of a group also starts 16
// reads of the store, one per cycle while the output buffer has room, during which no
// write happens, and results leave at one per cycle while a group is read out and
// result_stall is low. A 4-entry queue between front and back and a 2-entry buffer at
// the output keep both sides moving. A length write converts into groups in two
// registered steps; cfg_ready and item intake pause meanwhile.

module dab_time_interleaver_top
    import dti_pkg::*;
#(
    parameter int BRANCHES   = DTI_BRANCHES,
    parameter int MAX_VECTOR = DTI_MAX_VECTOR
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_stall,
    input  logic [SAMPLE_W-1:0]   sample_in,
    output logic                  result_valid,
    input  logic                  result_stall,
    output logic [SAMPLE_W-1:0]   sample_out,
    output logic                  group_last,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [TABLE_W-1:0] table_reg;
    logic [TABLE_W-1:0] table_next;
    logic               cfg_write;
    logic               len_wr;
    logic               len_busy;
    logic               clear_busy;
    logic               q_ready;
    logic               q_push;
    cmd_t               push_cmd;
    logic               q_pop;
    logic               q_valid;
    cmd_t               pop_cmd;

    // configuration decode
    assign cfg_ready = !len_busy;
    assign cfg_write = cfg_valid && cfg_ready;
    assign len_wr    = cfg_write && (cfg_index == REG_VEC_LEN);

    always_comb
    begin
        table_next = table_reg;
        if (cfg_write && (cfg_index == REG_SCRAMBLE_TABLE))
        begin
            table_next = cfg_data[TABLE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_reg <= TABLE_RESET;
        end
        else
        begin
            table_reg <= table_next;
        end
    end

    // front end
    dti_front #(
        .BRANCHES   (BRANCHES),
        .MAX_VECTOR (MAX_VECTOR)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .sample_in  (sample_in),
        .item_stall (item_stall),
        .len_wr     (len_wr),
        .len_data   (cfg_data[LEN_W-1:0]),
        .len_busy   (len_busy),
        .clear_busy (clear_busy),
        .q_ready    (q_ready),
        .q_push     (q_push),
        .q_cmd      (push_cmd)
    );

    // command queue
    dti_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_cmd   (push_cmd),
        .push_ready (q_ready),
        .pop        (q_pop),
        .pop_cmd    (pop_cmd),
        .pop_valid  (q_valid)
    );

    // back end
    dti_back #(
        .BRANCHES   (BRANCHES),
        .MAX_VECTOR (MAX_VECTOR)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (q_valid),
        .q_cmd          (pop_cmd),
        .q_pop          (q_pop),
        .scramble_table (table_reg),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .sample_out     (sample_out),
        .group_last     (group_last),
        .clear_busy     (clear_busy)
    );

`ifndef NO_ASSERTIONS
    // no result can exist while the store is still being cleared
    a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clear_busy |-> !result_valid)
        else $error("result offered during clearing sweep");

    // intake is closed during the clearing sweep
    a_stall_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clear_busy |-> item_stall)
        else $error("item intake open during clearing sweep");

    // a length write closes both config and item intake while it converts
    a_len_convert: assert property (@(posedge clk) disable iff (!rst_n)
        len_wr |=> (!cfg_ready && item_stall))
        else $error("intake open while vector length converts");

    // no command is popped while the store is being cleared
    a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clear_busy |-> !q_pop)
        else $error("command consumed during clearing sweep");
`endif

endmodule
